FILE: src/jcbe_pkg.sv
// ----------------------------------------------------------------------------
// jcbe_pkg: shared types and constants of the joybus command bit engine
// Holds the beat types, action and register codes and the command table.
// ----------------------------------------------------------------------------
package jcbe_pkg;

  localparam int unsigned ResponseBytes = 8;
  localparam int unsigned ByteCountW    = 5;
  localparam int unsigned BitIndexW     = 5;

  localparam logic [1:0] ActSend    = 2'd0;
  localparam logic [1:0] ActTick    = 2'd1;
  localparam logic [1:0] ActCapture = 2'd2;

  localparam logic [1:0] CmdProbe      = 2'd0;
  localparam logic [1:0] CmdPoll       = 2'd1;
  localparam logic [1:0] CmdOrigin     = 2'd2;
  localparam logic [1:0] CmdPollRumble = 2'd3;

  localparam logic [1:0] CfgOneCompare    = 2'd0;
  localparam logic [1:0] CfgZeroCompare   = 2'd1;
  localparam logic [1:0] CfgWidthThresh   = 2'd2;

  localparam logic [BitIndexW-1:0] ShortCmdBits = BitIndexW'(8);
  localparam logic [BitIndexW-1:0] LongCmdBits  = BitIndexW'(24);
  localparam logic [ByteCountW-1:0] RespBytesC  = ByteCountW'(ResponseBytes);

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  command;
    logic [15:0] pulse_width;
  } in_item_t;

  typedef struct packed {
    logic [7:0] compare_first;
    logic [7:0] compare_next;
    logic       compare_valid;
    logic       line_driven;
    logic       transmit_finished;
    logic [7:0] received_byte;
    logic       byte_valid;
    logic [3:0] byte_index;
    logic       response_done;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  one_compare;
    logic [7:0]  zero_compare;
    logic [15:0] width_threshold;
  } cfg_t;

  function automatic logic [7:0] cmd_byte(input logic [1:0] cmd, input logic [1:0] sel);
    logic [7:0] b;
    b = 8'h00;
    case (cmd)
      CmdPoll: begin
        if (sel == 2'd0) b = 8'h40;
        else if (sel == 2'd1) b = 8'h03;
      end
      CmdOrigin: begin
        if (sel == 2'd0) b = 8'h41;
      end
      CmdPollRumble: begin
        if (sel == 2'd0) b = 8'h40;
        else if (sel == 2'd1) b = 8'h03;
        else if (sel == 2'd2) b = 8'h01;
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic cmd_bit(input logic [1:0] cmd, input logic [BitIndexW-1:0] idx);
    logic [7:0] b;
    b = cmd_byte(cmd, idx[4:3]);
    return b[3'd7 - idx[2:0]];
  endfunction

  function automatic logic [BitIndexW-1:0] cmd_total(input logic [1:0] cmd);
    return (cmd == CmdPoll || cmd == CmdPollRumble) ? LongCmdBits : ShortCmdBits;
  endfunction

endpackage

FILE: src/jcbe_cfg_regs.sv
// ----------------------------------------------------------------------------
// jcbe_cfg_regs: configuration registers
// Holds the compare values and the width threshold written over the
// configuration channel.
// ----------------------------------------------------------------------------
module jcbe_cfg_regs import jcbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgOneCompare:  cfg_d.one_compare     = cfg_data_i[7:0];
        CfgZeroCompare: cfg_d.zero_compare    = cfg_data_i[7:0];
        CfgWidthThresh: cfg_d.width_threshold = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_compare     <= 8'd20;
      cfg_q.zero_compare    <= 8'd60;
      cfg_q.width_threshold <= 16'd40;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: src/jcbe_core.sv
// ----------------------------------------------------------------------------
// jcbe_core: transmit and receive state with the per-beat result logic
// Updates the protocol state and forms the result of one input beat when
// the beat moves from the input register to the result register.
// ----------------------------------------------------------------------------
module jcbe_core import jcbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  logic [1:0]            cmd_d, cmd_q;
  logic [BitIndexW-1:0]  idx_d, idx_q;
  logic [BitIndexW-1:0]  total_d, total_q;
  logic                  tx_d, tx_q;
  logic                  rx_d, rx_q;
  logic [7:0]            shift_d, shift_q;
  logic [2:0]            bitcnt_d, bitcnt_q;
  logic [ByteCountW-1:0] bytecnt_d, bytecnt_q;
  logic [7:0]            shift_new;
  logic [2:0]            bitcnt_new;
  logic [ByteCountW-1:0] bytecnt_new;

  always_comb begin
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    total_d   = total_q;
    tx_d      = tx_q;
    rx_d      = rx_q;
    shift_d   = shift_q;
    bitcnt_d  = bitcnt_q;
    bytecnt_d = bytecnt_q;
    result_o  = '0;
    shift_new   = {shift_q[6:0], (item_i.pulse_width < cfg_i.width_threshold)};
    bitcnt_new  = bitcnt_q + 3'd1;
    bytecnt_new = bytecnt_q + ByteCountW'(1);

    case (item_i.action)
      ActSend: begin
        cmd_d   = item_i.command;
        total_d = cmd_total(item_i.command);
        idx_d   = BitIndexW'(2);
        tx_d    = 1'b1;
        rx_d    = 1'b0;
        result_o.compare_first = cmd_bit(item_i.command, BitIndexW'(0)) ?
                                 cfg_i.one_compare : cfg_i.zero_compare;
        result_o.compare_next  = cmd_bit(item_i.command, BitIndexW'(1)) ?
                                 cfg_i.one_compare : cfg_i.zero_compare;
        result_o.compare_valid = 1'b1;
      end
      ActTick: begin
        if (tx_q) begin
          if (idx_q < total_q) begin
            result_o.compare_next  = cmd_bit(cmd_q, idx_q) ?
                                     cfg_i.one_compare : cfg_i.zero_compare;
            result_o.compare_valid = 1'b1;
            idx_d = idx_q + BitIndexW'(1);
          end else if (idx_q == total_q) begin
            result_o.compare_next  = cfg_i.one_compare;
            result_o.compare_valid = 1'b1;
            idx_d = idx_q + BitIndexW'(1);
          end else begin
            tx_d      = 1'b0;
            rx_d      = 1'b1;
            shift_d   = '0;
            bitcnt_d  = '0;
            bytecnt_d = '0;
            result_o.transmit_finished = 1'b1;
          end
        end
      end
      ActCapture: begin
        if (rx_q) begin
          shift_d  = shift_new;
          bitcnt_d = bitcnt_new;
          if (bitcnt_new == 3'd0) begin
            result_o.received_byte = shift_new;
            result_o.byte_valid    = 1'b1;
            result_o.byte_index    = bytecnt_q[3:0];
            bytecnt_d = bytecnt_new;
            shift_d   = '0;
            if (bytecnt_new >= RespBytesC) begin
              rx_d = 1'b0;
              result_o.response_done = 1'b1;
            end
          end
        end
      end
      default: begin
        result_o = '0;
      end
    endcase
    result_o.line_driven = tx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= '0;
      idx_q     <= '0;
      total_q   <= '0;
      tx_q      <= 1'b0;
      rx_q      <= 1'b0;
      shift_q   <= '0;
      bitcnt_q  <= '0;
      bytecnt_q <= '0;
    end else if (advance_i) begin
      cmd_q     <= cmd_d;
      idx_q     <= idx_d;
      total_q   <= total_d;
      tx_q      <= tx_d;
      rx_q      <= rx_d;
      shift_q   <= shift_d;
      bitcnt_q  <= bitcnt_d;
      bytecnt_q <= bytecnt_d;
    end
  end

  // The line is never driven while the receiver listens.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(tx_q && rx_q))
    else $error("transmit and receive active together");

  // The bit index never passes the stop bit by more than one step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   tx_q |-> (idx_q <= total_q + BitIndexW'(1)))
    else $error("transmit bit index out of range");

  // The receiver stops once the full response is in.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   rx_q |-> (bytecnt_q < RespBytesC))
    else $error("receiver active past the last response byte");

  // A finished response always comes with its last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   result_o.response_done |-> result_o.byte_valid)
    else $error("response done without a byte");

endmodule

FILE: src/joybus_command_bit_engine_unit.sv
// ----------------------------------------------------------------------------
// joybus_command_bit_engine_unit: bit engine for a one-wire controller link
// Turns send, tick and capture beats into compare values and response bytes.
//
// Input channel (in_valid_i, in_stall_o, in_data_i): one beat per event;
// a send picks a command, a tick asks for the next bit, a capture carries a
// measured low width. Output channel (out_valid_o, out_stall_i, out_data_o):
// exactly one result beat per input beat, in order.
// Configuration channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i):
// always ready; write only while no beats are in flight.
// A result passes through the input register, then the state update and result
// logic feed the result register; a receiver stall can hold a beat in between.
// Throughput is one beat per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds, the input register
// still takes one beat, and in_stall_o rises once both are full.
// Reset clears both valid flags and the transmit and receive state, and loads
// the register defaults (one 20, zero 60, threshold 40).
// ----------------------------------------------------------------------------
module joybus_command_bit_engine_unit import jcbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t      cfg;
  in_item_t  in_item_q;
  logic      in_valid_d, in_valid_q;
  out_item_t out_item_q, result;
  logic      out_valid_d, out_valid_q;
  logic      advance, accept;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  jcbe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  jcbe_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_item_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_data_i;
    end
    if (advance) begin
      out_item_q <= result;
    end
  end

endmodule
